[hw/rtl/pcs_pkg.sv]
// ---------------------------------------------------------------------------
// pcs_pkg: shared types and microcode for the pancake sorter
// Control word layout, sequencer condition flags, action and jump codes,
// and the read-only program that drives the sort datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

   localparam int PC_W  = 5;
   localparam int ACT_W = 4;
   localparam int JMP_W = 4;
   localparam int DATA_W = 32;

   // datapath actions
   localparam logic [ACT_W-1:0] A_NONE       = 4'd0;
   localparam logic [ACT_W-1:0] A_LOAD       = 4'd1;
   localparam logic [ACT_W-1:0] A_SIZE_INIT  = 4'd2;
   localparam logic [ACT_W-1:0] A_SCAN_START = 4'd3;
   localparam logic [ACT_W-1:0] A_MAX0       = 4'd4;
   localparam logic [ACT_W-1:0] A_SCAN       = 4'd5;
   localparam logic [ACT_W-1:0] A_REV1_SET   = 4'd6;
   localparam logic [ACT_W-1:0] A_REV2_SET   = 4'd7;
   localparam logic [ACT_W-1:0] A_REV_RDLO   = 4'd8;
   localparam logic [ACT_W-1:0] A_REV_RDHI   = 4'd9;
   localparam logic [ACT_W-1:0] A_REV_WRLO   = 4'd10;
   localparam logic [ACT_W-1:0] A_REV_WRHI   = 4'd11;
   localparam logic [ACT_W-1:0] A_SHRINK     = 4'd12;
   localparam logic [ACT_W-1:0] A_EMIT_SET   = 4'd13;
   localparam logic [ACT_W-1:0] A_EMIT_RD    = 4'd14;
   localparam logic [ACT_W-1:0] A_EMIT_WR    = 4'd15;

   // sequencer jump kinds
   localparam logic [JMP_W-1:0] J_NEXT      = 4'd0;
   localparam logic [JMP_W-1:0] J_GOTO      = 4'd1;
   localparam logic [JMP_W-1:0] J_IDLE      = 4'd2;
   localparam logic [JMP_W-1:0] J_SIZE_LE1  = 4'd3;
   localparam logic [JMP_W-1:0] J_SCAN      = 4'd4;
   localparam logic [JMP_W-1:0] J_BEST_LAST = 4'd5;
   localparam logic [JMP_W-1:0] J_BEST_ZERO = 4'd6;
   localparam logic [JMP_W-1:0] J_LO_GE_HI  = 4'd7;
   localparam logic [JMP_W-1:0] J_EMIT      = 4'd8;

   // program step addresses
   localparam logic [PC_W-1:0] S_IDLE     = 5'd0;
   localparam logic [PC_W-1:0] S_INIT     = 5'd1;
   localparam logic [PC_W-1:0] S_TOP      = 5'd2;
   localparam logic [PC_W-1:0] S_MAX0     = 5'd3;
   localparam logic [PC_W-1:0] S_SCAN     = 5'd4;
   localparam logic [PC_W-1:0] S_DEC1     = 5'd5;
   localparam logic [PC_W-1:0] S_DEC2     = 5'd6;
   localparam logic [PC_W-1:0] S_REV1_SET = 5'd7;
   localparam logic [PC_W-1:0] S_R1_RDLO  = 5'd8;
   localparam logic [PC_W-1:0] S_R1_RDHI  = 5'd9;
   localparam logic [PC_W-1:0] S_R1_WRLO  = 5'd10;
   localparam logic [PC_W-1:0] S_R1_WRHI  = 5'd11;
   localparam logic [PC_W-1:0] S_REV2_SET = 5'd12;
   localparam logic [PC_W-1:0] S_R2_RDLO  = 5'd13;
   localparam logic [PC_W-1:0] S_R2_RDHI  = 5'd14;
   localparam logic [PC_W-1:0] S_R2_WRLO  = 5'd15;
   localparam logic [PC_W-1:0] S_R2_WRHI  = 5'd16;
   localparam logic [PC_W-1:0] S_SHRINK   = 5'd17;
   localparam logic [PC_W-1:0] S_EMIT_SET = 5'd18;
   localparam logic [PC_W-1:0] S_EMIT_RD  = 5'd19;
   localparam logic [PC_W-1:0] S_EMIT_WR  = 5'd20;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic [JMP_W-1:0] jmp;
      logic [PC_W-1:0]  target;
   } pcs_ctrl_type;

   typedef struct packed {
      logic accept_last;
      logic size_le1;
      logic scan_done;
      logic best_last;
      logic best_zero;
      logic lo_ge_hi;
      logic emit_stall;
      logic emit_last;
   } pcs_cond_type;

   function automatic pcs_ctrl_type pcs_rom(input logic [PC_W-1:0] pc);
      pcs_ctrl_type w;
      unique case (pc)
         S_IDLE:     w = '{A_LOAD,       J_IDLE,      S_INIT};
         S_INIT:     w = '{A_SIZE_INIT,  J_NEXT,      S_IDLE};
         S_TOP:      w = '{A_SCAN_START, J_SIZE_LE1,  S_EMIT_SET};
         S_MAX0:     w = '{A_MAX0,       J_NEXT,      S_IDLE};
         S_SCAN:     w = '{A_SCAN,       J_SCAN,      S_DEC1};
         S_DEC1:     w = '{A_NONE,       J_BEST_LAST, S_SHRINK};
         S_DEC2:     w = '{A_NONE,       J_BEST_ZERO, S_REV2_SET};
         S_REV1_SET: w = '{A_REV1_SET,   J_NEXT,      S_IDLE};
         S_R1_RDLO:  w = '{A_REV_RDLO,   J_LO_GE_HI,  S_REV2_SET};
         S_R1_RDHI:  w = '{A_REV_RDHI,   J_NEXT,      S_IDLE};
         S_R1_WRLO:  w = '{A_REV_WRLO,   J_NEXT,      S_IDLE};
         S_R1_WRHI:  w = '{A_REV_WRHI,   J_GOTO,      S_R1_RDLO};
         S_REV2_SET: w = '{A_REV2_SET,   J_NEXT,      S_IDLE};
         S_R2_RDLO:  w = '{A_REV_RDLO,   J_LO_GE_HI,  S_SHRINK};
         S_R2_RDHI:  w = '{A_REV_RDHI,   J_NEXT,      S_IDLE};
         S_R2_WRLO:  w = '{A_REV_WRLO,   J_NEXT,      S_IDLE};
         S_R2_WRHI:  w = '{A_REV_WRHI,   J_GOTO,      S_R2_RDLO};
         S_SHRINK:   w = '{A_SHRINK,     J_GOTO,      S_TOP};
         S_EMIT_SET: w = '{A_EMIT_SET,   J_NEXT,      S_IDLE};
         S_EMIT_RD:  w = '{A_EMIT_RD,    J_NEXT,      S_IDLE};
         S_EMIT_WR:  w = '{A_EMIT_WR,    J_EMIT,      S_EMIT_RD};
         default:    w = '{A_NONE,       J_GOTO,      S_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/pancake_sorter_top.sv]
// ---------------------------------------------------------------------------
// pancake_sorter_top: stream sorter using pancake flips
// Collects signed elements, sorts them ascending when the last beat of a set
// arrives, then streams the sorted set out with the final beat marked.
// ---------------------------------------------------------------------------
// Elements load at one beat per clock into a single store of MAX_ELEMENTS
// entries; beats beyond capacity are dropped and flagged on tuser of every
// result of that run. The beat with tlast starts the sort, during which the
// input is not ready. For each prefix of size s (from the element count n
// down to 2) the store is scanned to find the first maximum, then up to two
// prefix reversals follow, each a setup step and then swaps of pairs from
// the ends inward. Results then leave one beat at a time; each is read from
// the store and loaded into the result register only once that register is
// free. The microcode program steps through the single store port pair
// (one read with registered data, one write per cycle).
`default_nettype none

module pancake_sorter_top
   import pcs_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // input stream
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,   // [31:0] value
   input  wire logic              req_tlast,   // last element of the set
   // result stream
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // [31:0] value_res
   output logic                   rsp_tlast,   // last sorted element
   output logic                   rsp_tuser    // [0] overflow
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

   pcs_ctrl_type ctrl;
   pcs_cond_type cond;

   // element store
   logic [DATA_W-1:0] mem [MAX_ELEMENTS];
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rdata_ff;

   // datapath registers
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              drop_ff, drop_in;
   logic [CW-1:0]     size_ff, size_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [AW-1:0]     best_ff, best_in;
   logic [DATA_W-1:0] bestval_ff, bestval_in;
   logic [AW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [DATA_W-1:0] tmp_ff, tmp_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              accept;
   logic              out_free;
   logic              emit_last;
   logic [CW-1:0]     size_m1;
   logic [CW-1:0]     k_nxt;

   pcs_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   assign req_tready = (ctrl.act == A_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign size_m1    = size_ff - 1'b1;
   assign k_nxt      = k_ff + 1'b1;
   assign emit_last  = (k_ff == (cnt_ff - 1'b1));

   // condition flags seen by the sequencer
   always_comb begin
      cond.accept_last = accept && req_tlast;
      cond.size_le1    = (size_ff <= CW'(1));
      cond.scan_done   = (k_ff == size_m1);
      cond.best_last   = (best_ff == size_m1[AW-1:0]);
      cond.best_zero   = (best_ff == '0);
      cond.lo_ge_hi    = (lo_ff >= hi_ff);
      cond.emit_stall  = !out_free;
      cond.emit_last   = emit_last;
   end

   // decode the control word into datapath updates
   always_comb begin
      cnt_in       = cnt_ff;
      drop_in      = drop_ff;
      size_in      = size_ff;
      k_in         = k_ff;
      best_in      = best_ff;
      bestval_in   = bestval_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rdata_ff;

      unique case (ctrl.act)
         A_LOAD: begin
            // store the beat, or drop it and flag the run once full
            if (accept) begin
               if (cnt_ff < MAX_CNT) begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[AW-1:0];
                  wr_data = req_tdata;
                  cnt_in  = cnt_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
            end
         end
         A_SIZE_INIT: begin
            size_in = cnt_ff;
         end
         A_SCAN_START: begin
            k_in    = CW'(1);
            best_in = '0;
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         A_MAX0: begin
            bestval_in = rdata_ff;
            rd_en      = 1'b1;
            rd_addr    = k_ff[AW-1:0];
         end
         A_SCAN: begin
            // strict compare keeps the first maximum
            if ($signed(rdata_ff) > $signed(bestval_ff)) begin
               best_in    = k_ff[AW-1:0];
               bestval_in = rdata_ff;
            end
            k_in    = k_nxt;
            rd_en   = 1'b1;
            rd_addr = k_nxt[AW-1:0];
         end
         A_REV1_SET: begin
            lo_in = '0;
            hi_in = best_ff;
         end
         A_REV2_SET: begin
            lo_in = '0;
            hi_in = size_m1[AW-1:0];
         end
         A_REV_RDLO: begin
            rd_en   = 1'b1;
            rd_addr = lo_ff;
         end
         A_REV_RDHI: begin
            tmp_in  = rdata_ff;
            rd_en   = 1'b1;
            rd_addr = hi_ff;
         end
         A_REV_WRLO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rdata_ff;
         end
         A_REV_WRHI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = tmp_ff;
            lo_in   = lo_ff + 1'b1;
            hi_in   = hi_ff - 1'b1;
         end
         A_SHRINK: begin
            size_in = size_m1;
         end
         A_EMIT_SET: begin
            k_in = '0;
         end
         A_EMIT_RD: begin
            rd_en   = 1'b1;
            rd_addr = k_ff[AW-1:0];
         end
         A_EMIT_WR: begin
            // load the result register once it frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rdata_ff;
               rsp_last_in  = emit_last;
               rsp_ovf_in   = drop_ff;
               k_in         = k_nxt;
               if (emit_last) begin
                  cnt_in  = '0;
                  drop_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      k_ff        <= k_in;
      best_ff     <= best_in;
      bestval_ff  <= bestval_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      tmp_ff      <= tmp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("element count beyond capacity");

   a_sort_nonempty: assert property (@(posedge clock) disable iff (reset)
      cond.accept_last |=> (cnt_ff != '0))
      else $error("sort started on an empty store");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.act == A_SCAN) |-> (k_ff < size_ff))
      else $error("max scan ran past the prefix");

   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      (ctrl.act == A_REV_WRHI) |-> (lo_ff < hi_ff))
      else $error("reversal swapped crossed indexes");
`endif

endmodule

`default_nettype wire

[hw/rtl/pcs_sequencer.sv]
// ---------------------------------------------------------------------------
// pcs_sequencer: microcode step counter for the pancake sorter
// Holds the step counter, reads the control word from the program table and
// resolves conditional jumps from the datapath flags.
// ---------------------------------------------------------------------------
`default_nettype none

module pcs_sequencer
   import pcs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire pcs_cond_type cond,
   output pcs_ctrl_type      ctrl
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic [PC_W-1:0] pc_next;

   assign ctrl    = pcs_rom(pc_ff);
   assign pc_next = pc_ff + 1'b1;

   always_comb begin
      unique case (ctrl.jmp)
         J_NEXT:      pc_in = pc_next;
         J_GOTO:      pc_in = ctrl.target;
         J_IDLE:      pc_in = cond.accept_last ? ctrl.target : pc_ff;
         J_SIZE_LE1:  pc_in = cond.size_le1 ? ctrl.target : pc_next;
         J_SCAN:      pc_in = cond.scan_done ? ctrl.target : pc_ff;
         J_BEST_LAST: pc_in = cond.best_last ? ctrl.target : pc_next;
         J_BEST_ZERO: pc_in = cond.best_zero ? ctrl.target : pc_next;
         J_LO_GE_HI:  pc_in = cond.lo_ge_hi ? ctrl.target : pc_next;
         J_EMIT: begin
            // hold while the result register is occupied
            priority if (cond.emit_stall) pc_in = pc_ff;
            else if (cond.emit_last)       pc_in = S_IDLE;
            else                           pc_in = ctrl.target;
         end
         default:     pc_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire
